FILE: rtl/bc_pkg.sv
package bc_pkg;

	// divider depth: one quotient bit per stage
	localparam int DivStages = 32;

	// configuration register indexes
	localparam logic [1:0] CfgCalA = 2'd0;
	localparam logic [1:0] CfgCalB = 2'd1;
	localparam logic [1:0] CfgCalC = 2'd2;
	localparam logic [1:0] CfgOsr  = 2'd3;

	// sideband carried alongside a division
	typedef struct packed {
		logic        err;
		logic        neg;
		logic        post_shl;
		logic [31:0] word;
		logic [18:0] up;
		logic [15:0] temp;
	} bc_side_t;

	// arithmetic shift right of a 32-bit two's complement word
	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		return $signed(x) >>> n;
	endfunction

	// sign-extend a 16-bit coefficient
	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

FILE: rtl/barometer_compensation.sv
// Barometer compensation pipeline. Pulse start with a raw temperature word and the
// three raw pressure bytes; one item may be started every clock cycle and busy
// never rises. Each result appears on temperature_tenths (0.1 degC, saturated),
// pressure_pa (Pa, saturated to 0..1048575) and divide_error for exactly one
// cycle, marked by done. There is no back-pressure: the receiver must take every
// result when done is high. The pipe consists mainly of two 32-stage dividers,
// each resolving one quotient bit per stage (temperature division, then pressure
// division), plus the multiply and shift stages around them. A zero divisor sets
// divide_error and forces both results to zero. Calibration and oversampling are
// written on the cfg port (index 0..3: group a, group b, group c, oversampling)
// and must only change while no transfer is in flight.
module barometer_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] raw_temperature,
	input  logic [23:0] raw_pressure_bytes,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic signed [15:0] temperature_tenths,
	output logic [19:0] pressure_pa,
	output logic        divide_error
);

	localparam int Latency = 3 + bc_pkg::DivStages + 9 + bc_pkg::DivStages + 5;

	// ---------------- configuration ----------------
	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  os_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			os_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bc_pkg::CfgCalA: cal_a_q <= cfg_data;
				bc_pkg::CfgCalB: cal_b_q <= cfg_data;
				bc_pkg::CfgCalC: cal_c_q <= cfg_data[31:0];
				bc_pkg::CfgOsr:  os_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// decoded coefficients, all held as 32-bit words
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bc_pkg::sext16(cal_a_q[15:0]);
	assign ac2 = bc_pkg::sext16(cal_a_q[31:16]);
	assign ac3 = bc_pkg::sext16(cal_a_q[47:32]);
	assign ac4 = {16'b0, cal_a_q[63:48]};
	assign ac5 = {16'b0, cal_b_q[15:0]};
	assign ac6 = {16'b0, cal_b_q[31:16]};
	assign b1  = bc_pkg::sext16(cal_b_q[47:32]);
	assign b2  = bc_pkg::sext16(cal_b_q[63:48]);
	assign mc  = bc_pkg::sext16(cal_c_q[15:0]);
	assign md  = bc_pkg::sext16(cal_c_q[31:16]);

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- s1: raw temperature product ----------------
	logic        v_s1;
	logic [31:0] m_s1;
	logic [18:0] up_s1;
	logic [31:0] ut_diff;
	logic [23:0] up_sh;

	assign ut_diff = {16'b0, raw_temperature} - ac6;
	assign up_sh   = raw_pressure_bytes >> (4'd8 - {2'b0, os_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		m_s1  <= 32'(ut_diff * ac5);
		up_s1 <= up_sh[18:0];
	end

	// ---------------- s2: x1 and temperature divisor ----------------
	logic        v_s2;
	logic [31:0] x1_s2, den_s2;
	logic [18:0] up_s2;
	logic [31:0] x1_t;

	assign x1_t = bc_pkg::asr(m_s1, 5'd15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x1_s2  <= x1_t;
		den_s2 <= x1_t + md;
		up_s2  <= up_s1;
	end

	// ---------------- s3: magnitudes for the signed division ----------------
	logic             v_s3;
	logic [31:0]      n_s3, d_s3;
	bc_pkg::bc_side_t side_s3;
	logic [31:0]      num_t;

	assign num_t = 32'(mc << 11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s3              <= num_t[31] ? -num_t : num_t;
		d_s3              <= den_s2[31] ? -den_s2 : den_s2;
		side_s3.err       <= (den_s2 == '0);
		side_s3.neg       <= num_t[31] ^ den_s2[31];
		side_s3.post_shl  <= 1'b0;
		side_s3.word      <= x1_s2;
		side_s3.up        <= up_s2;
		side_s3.temp      <= '0;
	end

	logic             dv1_v;
	logic [31:0]      dv1_q;
	bc_pkg::bc_side_t dv1_side;

	bc_udiv u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num       (n_s3),
		.den       (d_s3),
		.in_side   (side_s3),
		.out_valid (dv1_v),
		.quo       (dv1_q),
		.out_side  (dv1_side)
	);

	// ---------------- s4: b5 ----------------
	logic        v_s4, err_s4;
	logic [31:0] b5_s4;
	logic [18:0] up_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= dv1_v;
		end
	end

	always_ff @(posedge clk) begin
		b5_s4  <= dv1_side.word + (dv1_side.neg ? -dv1_q : dv1_q);
		err_s4 <= dv1_side.err;
		up_s4  <= dv1_side.up;
	end

	// ---------------- s5: temperature and b6 ----------------
	logic        v_s5, err_s5;
	logic [15:0] temp_s5;
	logic [31:0] b6_s5;
	logic [18:0] up_s5;
	logic [31:0] tw;
	logic [15:0] t_sat;

	assign tw = bc_pkg::asr(b5_s4 + 32'd8, 5'd4);

	always_comb begin
		if (!tw[31] && (tw[30:15] != '0)) begin
			t_sat = 16'h7FFF;
		end else if (tw[31] && (tw[30:15] != '1)) begin
			t_sat = 16'h8000;
		end else begin
			t_sat = tw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		temp_s5 <= t_sat;
		b6_s5   <= b5_s4 - 32'd4000;
		err_s5  <= err_s4;
		up_s5   <= up_s4;
	end

	// ---------------- s6: products of b6 ----------------
	logic        v_s6, err_s6;
	logic [15:0] temp_s6;
	logic [31:0] sqm_s6, p1_s6, p3_s6;
	logic [18:0] up_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sqm_s6  <= 32'(b6_s5 * b6_s5);
		p1_s6   <= 32'(ac2 * b6_s5);
		p3_s6   <= 32'(ac3 * b6_s5);
		temp_s6 <= temp_s5;
		err_s6  <= err_s5;
		up_s6   <= up_s5;
	end

	// ---------------- s7: scale ----------------
	logic        v_s7, err_s7;
	logic [15:0] temp_s7;
	logic [31:0] sq_s7, x2a_s7, x1c_s7;
	logic [18:0] up_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		sq_s7   <= bc_pkg::asr(sqm_s6, 5'd12);
		x2a_s7  <= bc_pkg::asr(p1_s6, 5'd11);
		x1c_s7  <= bc_pkg::asr(p3_s6, 5'd13);
		temp_s7 <= temp_s6;
		err_s7  <= err_s6;
		up_s7   <= up_s6;
	end

	// ---------------- s8: products of sq ----------------
	logic        v_s8, err_s8;
	logic [15:0] temp_s8;
	logic [31:0] m1_s8, m2_s8, x2a_s8, x1c_s8;
	logic [18:0] up_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		m1_s8   <= 32'(b2 * sq_s7);
		m2_s8   <= 32'(b1 * sq_s7);
		x2a_s8  <= x2a_s7;
		x1c_s8  <= x1c_s7;
		temp_s8 <= temp_s7;
		err_s8  <= err_s7;
		up_s8   <= up_s7;
	end

	// ---------------- s9: sums for b3 and b4 ----------------
	logic        v_s9, err_s9;
	logic [15:0] temp_s9;
	logic [31:0] sum3_s9, x3b_s9;
	logic [18:0] up_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		sum3_s9 <= 32'(ac1 << 2) + bc_pkg::asr(m1_s8, 5'd11) + x2a_s8;
		x3b_s9  <= bc_pkg::asr(x1c_s8 + bc_pkg::asr(m2_s8, 5'd16) + 32'd2, 5'd2);
		temp_s9 <= temp_s8;
		err_s9  <= err_s8;
		up_s9   <= up_s8;
	end

	// ---------------- s10: b3 ----------------
	logic        v_s10, err_s10;
	logic [15:0] temp_s10;
	logic [31:0] b3_s10, w_s10;
	logic [18:0] up_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		b3_s10   <= bc_pkg::asr(32'(sum3_s9 << os_q) + 32'd2, 5'd2);
		w_s10    <= x3b_s9 + 32'd32768;
		temp_s10 <= temp_s9;
		err_s10  <= err_s9;
		up_s10   <= up_s9;
	end

	// ---------------- s11: up - b3 ----------------
	logic        v_s11, err_s11;
	logic [15:0] temp_s11;
	logic [31:0] diff_s11, w_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		diff_s11 <= {13'b0, up_s10} - b3_s10;
		w_s11    <= w_s10;
		temp_s11 <= temp_s10;
		err_s11  <= err_s10;
	end

	// ---------------- s12: b4 and b7 products ----------------
	logic        v_s12, err_s12;
	logic [15:0] temp_s12;
	logic [31:0] b4m_s12, b7_s12;
	logic [31:0] k_os;

	assign k_os = 32'd50000 >> os_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		b4m_s12  <= 32'(ac4 * w_s11);
		b7_s12   <= 32'(diff_s11 * k_os);
		temp_s12 <= temp_s11;
		err_s12  <= err_s11;
	end

	// divider feed: split on the top bit of b7
	logic [31:0]      b4;
	logic [31:0]      n_p;
	bc_pkg::bc_side_t side_p;

	always_comb begin
		b4              = b4m_s12 >> 15;
		n_p             = b7_s12[31] ? b7_s12 : {b7_s12[30:0], 1'b0};
		side_p          = '0;
		side_p.err      = err_s12 || (b4 == '0);
		side_p.post_shl = b7_s12[31];
		side_p.temp     = temp_s12;
	end

	logic             dv2_v;
	logic [31:0]      dv2_q;
	bc_pkg::bc_side_t dv2_side;

	bc_udiv u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s12),
		.num       (n_p),
		.den       (b4),
		.in_side   (side_p),
		.out_valid (dv2_v),
		.quo       (dv2_q),
		.out_side  (dv2_side)
	);

	// ---------------- s14: p ----------------
	logic        v_s14, err_s14;
	logic [15:0] temp_s14;
	logic [31:0] p_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
		end else begin
			v_s14 <= dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		p_s14    <= dv2_side.post_shl ? {dv2_q[30:0], 1'b0} : dv2_q;
		temp_s14 <= dv2_side.temp;
		err_s14  <= dv2_side.err;
	end

	// ---------------- s15: correction products ----------------
	logic        v_s15, err_s15;
	logic [15:0] temp_s15;
	logic [31:0] p_s15, sq2_s15, m7_s15;
	logic [31:0] a8;

	assign a8 = bc_pkg::asr(p_s14, 5'd8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else begin
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		sq2_s15  <= 32'(a8 * a8);
		m7_s15   <= 32'(p_s14 * 32'hFFFF_E343);    // times -7357
		p_s15    <= p_s14;
		temp_s15 <= temp_s14;
		err_s15  <= err_s14;
	end

	// ---------------- s16 ----------------
	logic        v_s16, err_s16;
	logic [15:0] temp_s16;
	logic [31:0] p_s16, m3_s16, x2b_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else begin
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		m3_s16   <= 32'(sq2_s15 * 32'd3038);
		x2b_s16  <= bc_pkg::asr(m7_s15, 5'd16);
		p_s16    <= p_s15;
		temp_s16 <= temp_s15;
		err_s16  <= err_s15;
	end

	// ---------------- s17 ----------------
	logic        v_s17, err_s17;
	logic [15:0] temp_s17;
	logic [31:0] p_s17, s_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
		end else begin
			v_s17 <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		s_s17    <= bc_pkg::asr(m3_s16, 5'd16) + x2b_s16 + 32'd3791;
		p_s17    <= p_s16;
		temp_s17 <= temp_s16;
		err_s17  <= err_s16;
	end

	// ---------------- output register: final pressure, saturation ----------------
	logic [31:0] pf;
	logic [19:0] p_sat;

	assign pf = p_s17 + bc_pkg::asr(s_s17, 5'd4);

	always_comb begin
		if (pf[31]) begin
			p_sat = '0;
		end else if (pf[30:20] != '0) begin
			p_sat = '1;
		end else begin
			p_sat = pf[19:0];
		end
	end

	logic        done_q;
	logic [15:0] temp_q;
	logic [19:0] pres_q;
	logic        err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s17;
		end
	end

	always_ff @(posedge clk) begin
		temp_q <= err_s17 ? 16'd0 : temp_s17;
		pres_q <= err_s17 ? 20'd0 : p_sat;
		err_q  <= err_s17;
	end

	assign done               = done_q;
	assign temperature_tenths = temp_q;
	assign pressure_pa        = pres_q;
	assign divide_error       = err_q;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##Latency done)
		else $error("result strobe missing after fixed latency");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_error |-> (temperature_tenths == 16'sd0) && (pressure_pa == 20'd0))
		else $error("divide error with non-zero results");

	// nine stages (s4..s12) sit between the two dividers
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		dv1_v |-> ##(bc_pkg::DivStages + 9) dv2_v)
		else $error("pressure divider out of step with temperature divider");

endmodule

FILE: rtl/bc_udiv.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
module bc_udiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       num,
	input  logic [31:0]       den,
	input  bc_pkg::bc_side_t  in_side,
	output logic              out_valid,
	output logic [31:0]       quo,
	output bc_pkg::bc_side_t  out_side
);

	logic              v_s    [bc_pkg::DivStages];
	logic [31:0]       n_s    [bc_pkg::DivStages];
	logic [31:0]       d_s    [bc_pkg::DivStages];
	logic [31:0]       r_s    [bc_pkg::DivStages];
	logic [31:0]       q_s    [bc_pkg::DivStages];
	bc_pkg::bc_side_t  side_s [bc_pkg::DivStages];

	for (genvar k = 0; k < bc_pkg::DivStages; k++) begin : g_stage
		logic              v_in;
		logic [31:0]       n_in, d_in, r_in, q_in;
		bc_pkg::bc_side_t  side_in;
		logic [32:0]       trial;
		logic              ge;
		logic [32:0]       diff;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign n_in    = num;
			assign d_in    = den;
			assign r_in    = '0;
			assign q_in    = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign n_in    = n_s[k-1];
			assign d_in    = d_s[k-1];
			assign r_in    = r_s[k-1];
			assign q_in    = q_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			trial = {r_in, n_in[31]};
			diff  = trial - {1'b0, d_in};
			ge    = (trial >= {1'b0, d_in});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			n_s[k]    <= {n_in[30:0], 1'b0};
			d_s[k]    <= d_in;
			r_s[k]    <= ge ? diff[31:0] : trial[31:0];
			q_s[k]    <= {q_in[30:0], ge};
			side_s[k] <= side_in;
		end
	end

	assign out_valid = v_s[bc_pkg::DivStages-1];
	assign quo       = q_s[bc_pkg::DivStages-1];
	assign out_side  = side_s[bc_pkg::DivStages-1];

endmodule

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// fixed latency of the pipeline, start transfer to done
	localparam int PipeLatency = 81;
	localparam int CycleLimit  = 2000000;

	// one expected result
	typedef struct {
		logic signed [15:0] temp;
		logic [19:0]        press;
		logic               derr;
	} reading_t;

	// Scoreboard: owns the calibration copy and the queue of expected readings
	class reading_board;
		logic [63:0] cal_a, cal_b;
		logic [31:0] cal_c;
		logic [1:0]  osr;
		reading_t    pending[$];
		int          errors, checked, div_errors, clipped;

		function new();
			cal_a = '0; cal_b = '0; cal_c = '0; osr = '0;
			errors = 0; checked = 0; div_errors = 0; clipped = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				bc_pkg::CfgCalA: cal_a = val;
				bc_pkg::CfgCalB: cal_b = val;
				bc_pkg::CfgCalC: cal_c = val[31:0];
				bc_pkg::CfgOsr:  osr = val[1:0];
				default: ;
			endcase
		endfunction

		static function logic [31:0] sx(logic [15:0] v);
			return {{16{v[15]}}, v};
		endfunction

		static function logic [31:0] sra(logic [31:0] x, int n);
			return $signed(x) >>> n;
		endfunction

		// integer compensation formula, 32-bit wrapping arithmetic
		function reading_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
			logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
			logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den;
			logic signed [31:0] t;
			logic signed [63:0] q;
			reading_t r;
			ac1 = sx(cal_a[15:0]);  ac2 = sx(cal_a[31:16]);
			ac3 = sx(cal_a[47:32]); ac4 = {16'h0, cal_a[63:48]};
			ac5 = {16'h0, cal_b[15:0]}; ac6 = {16'h0, cal_b[31:16]};
			b1 = sx(cal_b[47:32]); b2 = sx(cal_b[63:48]);
			mc = sx(cal_c[15:0]); md = sx(cal_c[31:16]);
			ut = {16'h0, ut_raw};
			up = {8'h0, up_raw} >> (8 - osr);
			r.temp = '0; r.press = '0; r.derr = 1'b1;
			x1 = sra((ut - ac6) * ac5, 15);
			den = x1 + md;
			if (den == 0) return r;
			q = $signed({{32{mc[31]}}, mc << 11}) / $signed({{32{den[31]}}, den});
			x2 = q[31:0];
			b5 = x1 + x2;
			t = sra(b5 + 8, 4);
			b6 = b5 - 4000;
			sq = sra(b6 * b6, 12);
			x1 = sra(b2 * sq, 11);
			x2 = sra(ac2 * b6, 11);
			x3 = x1 + x2;
			b3 = sra((((ac1 << 2) + x3) << osr) + 2, 2);
			x1 = sra(ac3 * b6, 13);
			x2 = sra(b1 * sq, 16);
			x3 = sra(x1 + x2 + 2, 2);
			b4 = (ac4 * (x3 + 32768)) >> 15;
			if (b4 == 0) return r;
			b7 = (up - b3) * (32'd50000 >> osr);
			if (!b7[31]) p = (b7 << 1) / b4;
			else p = (b7 / b4) << 1;
			x1 = sra(p, 8) * sra(p, 8);
			x1 = sra(x1 * 3038, 16);
			x2 = sra((32'd0 - 32'd7357) * p, 16);
			p = p + sra(x1 + x2 + 3791, 4);
			r.derr = 1'b0;
			if (t > 32767) r.temp = 16'sh7fff;
			else if (t < -32768) r.temp = 16'sh8000;
			else r.temp = t[15:0];
			if ($signed(p) < 0) r.press = '0;
			else if ($signed(p) > 1048575) r.press = 20'hfffff;
			else r.press = p[19:0];
			return r;
		endfunction

		function void note_input(logic [15:0] ut_raw, logic [23:0] up_raw);
			pending.push_back(compensate(ut_raw, up_raw));
		endfunction

		function void check_result(logic signed [15:0] temp, logic [19:0] press,
				logic derr);
			reading_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result t=%0d p=%0d err=%0b",
					$time, temp, press, derr);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.derr) div_errors++;
			if (!e.derr && (e.press == 20'hfffff || e.press == 0)) clipped++;
			if (temp !== e.temp || press !== e.press || derr !== e.derr) begin
				$display("%0t: mismatch expected t=%0d p=%0d err=%0b, actual t=%0d p=%0d err=%0b",
					$time, e.temp, e.press, e.derr, temp, press, derr);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] raw_temperature = '0;
	logic [23:0] raw_pressure_bytes = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        done;
	logic signed [15:0] temperature_tenths;
	logic [19:0] pressure_pa;
	logic        divide_error;

	reading_board board = new();
	int cycles = 0;
	int sent = 0;

	barometer_compensation dut (
		.clk, .arst_n, .start, .busy, .raw_temperature, .raw_pressure_bytes,
		.cfg_we, .cfg_index, .cfg_data, .done, .temperature_tenths,
		.pressure_pa, .divide_error
	);

	always #6 clk = ~clk;

	// results are sampled at the rising edge; there is no back-pressure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			board.check_result(temperature_tenths, pressure_pa, divide_error);
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one register write, only while the pipeline is empty
	task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one sample transfer; start stays high across back-to-back transfers
	task automatic send_sample(logic [15:0] ut, logic [23:0] up, int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		raw_temperature = ut;
		raw_pressure_bytes = up;
		do @(posedge clk); while (busy);
		board.note_input(ut, up);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// a plausible factory set with a random spread on every coefficient, or raw random words if not typical
	task automatic load_cal(bit typical);
		logic [63:0] a, b;
		logic [31:0] c;
		if (typical) begin
			a = {16'(32741 + $urandom_range(0, 400) - 200),
				16'(-14383 + $urandom_range(0, 400) - 200),
				16'(-1131 + $urandom_range(0, 200) - 100),
				16'(408 + $urandom_range(0, 200) - 100)};
			b = {16'(4 + $urandom_range(0, 8) - 4), 16'(6190 + $urandom_range(0, 200) - 100),
				16'(23153 + $urandom_range(0, 400) - 200),
				16'(32757 + $urandom_range(0, 400) - 200)};
			c = {16'(2868 + $urandom_range(0, 200) - 100),
				16'(-8711 + $urandom_range(0, 400) - 200)};
		end else begin
			a = {$urandom, $urandom}; b = {$urandom, $urandom}; c = $urandom;
		end
		write_cfg(bc_pkg::CfgCalA, a);
		write_cfg(bc_pkg::CfgCalB, b);
		write_cfg(bc_pkg::CfgCalC, c);
	endtask

	function automatic int draw_gap();
		// stretches with no idling at all, otherwise a uniformly drawn idle gap
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all registers zero after reset: ac5 = md = 0 gives a zero divisor
		send_sample(16'h0000, 24'h000000, 0);
		send_sample(16'hffff, 24'hffffff, 0);
		drain();

		// zero temperature divisor with a live calibration: ac5 = 0 gives x1 = 0, and md = 0
		write_cfg(bc_pkg::CfgCalA, 64'h8000_c000_b000_7fff);
		write_cfg(bc_pkg::CfgCalB, 64'h8000_7fff_0000_0000);
		write_cfg(bc_pkg::CfgCalC, 64'h0000_0000);
		write_cfg(bc_pkg::CfgOsr, 2'd0);
		send_sample(16'h1234, 24'h800000, 1);
		drain();

		// zero pressure divisor: ac4 = 0
		write_cfg(bc_pkg::CfgCalA, 64'h0000_fb93_c7d1_1998);
		write_cfg(bc_pkg::CfgCalB, 64'h0004_5a71_182e_6190);
		write_cfg(bc_pkg::CfgCalC, 64'hd5d0_0b34);
		send_sample(16'd27898, 24'h5d2300, 0);
		drain();

		// typical calibration, all oversampling settings, field extremes
		write_cfg(bc_pkg::CfgCalA, 64'h7fe5_fb93_c7d1_1998);
		for (int os = 0; os < 4; os++) begin
			write_cfg(bc_pkg::CfgOsr, 2'(os));
			send_sample(16'd27898, 24'h5d2300, 0);
			send_sample(16'h0000, 24'h000000, 0);
			send_sample(16'hffff, 24'hffffff, 0);
			send_sample(16'h8000, 24'h800000, 2);
			drain();
		end

		// extreme coefficients push both outputs into saturation
		write_cfg(bc_pkg::CfgCalA, 64'hffff_8000_8000_8000);
		write_cfg(bc_pkg::CfgCalB, 64'h7fff_7fff_0000_ffff);
		write_cfg(bc_pkg::CfgCalC, 64'h0001_7fff);
		send_sample(16'hffff, 24'hffffff, 0);
		send_sample(16'h0000, 24'h000001, 0);
		drain();

		// random phases: mostly realistic calibration, some raw noise
		for (int ph = 0; ph < 23; ph++) begin
			load_cal($urandom_range(0, 4) != 0);
			write_cfg(bc_pkg::CfgOsr, 2'($urandom_range(0, 3)));
			for (int i = 0; i < 50; i++)
				send_sample($urandom_range(0, 3) == 0 ? 16'($urandom) :
					16'($urandom_range(22000, 34000)), 24'($urandom), draw_gap());
			drain();
		end
		repeat (PipeLatency + 20) @(posedge clk);

		$display("samples sent %0d, results checked %0d", sent, board.checked);
		$display("divide errors %0d, pressure at a limit %0d",
			board.div_errors, board.clipped);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
